### hw/rtl/assert_macros.svh
// Assertion macros used by the top level of the mode and expression controller.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge. The check is off while reset is asserted.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

### hw/rtl/mec_pkg.sv
// Types, codes and reset constants of the mode and expression controller.
package mec_pkg;

	localparam int unsigned HoldWidth = 16;
	localparam int unsigned TimeWidth = 32;

	localparam logic [HoldWidth-1:0] TouchHoldReset  = 16'd2500;
	localparam logic [HoldWidth-1:0] MotionHoldReset = 16'd1500;
	localparam logic [HoldWidth-1:0] ShakeHoldReset  = 16'd2000;
	localparam logic [HoldWidth-1:0] RewardHoldReset = 16'd3000;

	typedef enum logic [3:0] {
		OP_BOOT        = 4'd0,
		OP_TAP         = 4'd1,
		OP_LONG_PRESS  = 4'd2,
		OP_MOTION      = 4'd3,
		OP_SHAKE       = 4'd4,
		OP_TRAIN_OK    = 4'd5,
		OP_SET_MODE    = 4'd6,
		OP_PING        = 4'd7,
		OP_ROUTE_A     = 4'd8,
		OP_ROUTE_B     = 4'd9,
		OP_ROUTE_C     = 4'd10,
		OP_ALERT_RAISE = 4'd11,
		OP_ALERT_CLEAR = 4'd12,
		OP_TICK        = 4'd13
	} op_t;

	typedef enum logic [2:0] {
		MODE_IDLE       = 3'd0,
		MODE_COMPANION  = 3'd1,
		MODE_TRAINING   = 3'd2,
		MODE_MONITORING = 3'd3,
		MODE_ALERT      = 3'd4,
		MODE_ERROR      = 3'd5
	} mode_t;

	typedef enum logic [2:0] {
		EXPR_NEUTRAL     = 3'd0,
		EXPR_HAPPY       = 3'd1,
		EXPR_CURIOUS     = 3'd2,
		EXPR_ENCOURAGING = 3'd3,
		EXPR_SLEEPY      = 3'd4,
		EXPR_WARNING     = 3'd5,
		EXPR_ERROR       = 3'd6
	} expr_t;

	typedef enum logic [2:0] {
		REASON_NONE     = 3'd0,
		REASON_NO_ALERT = 3'd1,
		REASON_LATCHED  = 3'd2,
		REASON_CONTEXT  = 3'd3,
		REASON_ROUTE    = 3'd4
	} reason_t;

	typedef enum logic [1:0] {
		REG_TOUCH_HOLD  = 2'd0,
		REG_MOTION_HOLD = 2'd1,
		REG_SHAKE_HOLD  = 2'd2,
		REG_REWARD_HOLD = 2'd3
	} cfg_reg_t;

	typedef struct packed {
		logic [HoldWidth-1:0] touch;
		logic [HoldWidth-1:0] motion;
		logic [HoldWidth-1:0] shake;
		logic [HoldWidth-1:0] reward;
	} holds_t;

	typedef struct packed {
		mode_t                mode;
		expr_t                expr;
		logic [TimeWidth-1:0] expiry;
		logic                 latch;
		logic [TimeWidth-1:0] entry_time;
		logic [TimeWidth-1:0] touch_time;
		logic [TimeWidth-1:0] revision;
	} state_t;

	typedef struct packed {
		logic                 accepted;
		logic                 changed;
		reason_t              reason;
		mode_t                mode;
		expr_t                expr;
		logic                 alert;
		logic [TimeWidth-1:0] revision;
		logic [TimeWidth-1:0] expiry;
	} result_t;

	function automatic expr_t base_expr(input mode_t mode);
		expr_t e;
		unique case (mode)
			MODE_IDLE:       e = EXPR_NEUTRAL;
			MODE_COMPANION:  e = EXPR_CURIOUS;
			MODE_TRAINING:   e = EXPR_CURIOUS;
			MODE_MONITORING: e = EXPR_SLEEPY;
			MODE_ALERT:      e = EXPR_WARNING;
			MODE_ERROR:      e = EXPR_ERROR;
			default:         e = EXPR_NEUTRAL;
		endcase
		return e;
	endfunction

endpackage

### hw/rtl/mec_step.sv
// Next-state and result logic for one event of the mode and expression controller.
module mec_step (
	input  mec_pkg::state_t                  cur,
	input  mec_pkg::holds_t                  holds,
	input  logic [3:0]                       operation,
	input  logic [mec_pkg::TimeWidth-1:0]    event_time,
	input  logic [2:0]                       target_mode,
	output mec_pkg::state_t                  nxt,
	output mec_pkg::result_t                 res
);

	mec_pkg::op_t                  op;
	logic [mec_pkg::HoldWidth-1:0] hold;
	logic [mec_pkg::TimeWidth-1:0] expiry_sum;
	mec_pkg::mode_t                req;
	mec_pkg::state_t               work;
	logic                          ok;
	logic                          chg;
	mec_pkg::reason_t              why;

	assign op         = mec_pkg::op_t'(operation);
	assign req        = mec_pkg::mode_t'(target_mode);
	assign expiry_sum = event_time + mec_pkg::TimeWidth'(hold);

	always_comb begin
		unique case (op)
			mec_pkg::OP_MOTION:   hold = holds.motion;
			mec_pkg::OP_SHAKE:    hold = holds.shake;
			mec_pkg::OP_TRAIN_OK: hold = holds.reward;
			default:              hold = holds.touch;
		endcase
	end

	always_comb begin
		work = cur;
		ok   = 1'b1;
		chg  = 1'b0;
		why  = mec_pkg::REASON_NONE;
		unique case (op)
			mec_pkg::OP_TICK: begin
				if (cur.expiry != '0 && event_time >= cur.expiry) begin
					work.expr   = mec_pkg::base_expr(cur.mode);
					work.expiry = '0;
					chg         = 1'b1;
				end
			end
			mec_pkg::OP_ALERT_RAISE: begin
				work.latch  = 1'b1;
				work.mode   = mec_pkg::MODE_ALERT;
				work.expr   = mec_pkg::EXPR_WARNING;
				work.expiry = '0;
				if (cur.mode != mec_pkg::MODE_ALERT) begin
					work.entry_time = event_time;
				end
				chg = (cur.mode != mec_pkg::MODE_ALERT) || (cur.expr != mec_pkg::EXPR_WARNING);
			end
			mec_pkg::OP_ALERT_CLEAR: begin
				if (!cur.latch) begin
					ok  = 1'b0;
					why = mec_pkg::REASON_NO_ALERT;
				end else begin
					work.latch  = 1'b0;
					work.mode   = mec_pkg::MODE_MONITORING;
					work.expr   = mec_pkg::EXPR_SLEEPY;
					work.expiry = '0;
					if (cur.mode != mec_pkg::MODE_MONITORING) begin
						work.entry_time = event_time;
					end
					chg = (cur.mode != mec_pkg::MODE_MONITORING)
						|| (cur.expr != mec_pkg::EXPR_SLEEPY);
				end
			end
			default: begin
				if (cur.latch) begin
					ok  = 1'b0;
					why = mec_pkg::REASON_LATCHED;
				end else begin
					unique case (op)
						mec_pkg::OP_BOOT: begin
							work.mode   = mec_pkg::MODE_IDLE;
							work.expr   = mec_pkg::EXPR_NEUTRAL;
							work.expiry = '0;
							if (cur.mode != mec_pkg::MODE_IDLE) begin
								work.entry_time = event_time;
							end
							chg = (cur.mode != mec_pkg::MODE_IDLE)
								|| (cur.expr != mec_pkg::EXPR_NEUTRAL);
						end
						mec_pkg::OP_TAP: begin
							// A tap in idle wakes the block into companion mode first.
							work.touch_time = event_time;
							work.expr       = mec_pkg::EXPR_HAPPY;
							work.expiry     = expiry_sum;
							if (cur.mode == mec_pkg::MODE_IDLE) begin
								work.mode       = mec_pkg::MODE_COMPANION;
								work.entry_time = event_time;
								chg             = 1'b1;
							end else begin
								chg = (cur.expr != mec_pkg::EXPR_HAPPY)
									|| (cur.expiry != expiry_sum);
							end
						end
						mec_pkg::OP_LONG_PRESS: begin
							work.touch_time = event_time;
							work.mode       = mec_pkg::MODE_COMPANION;
							work.expr       = mec_pkg::EXPR_CURIOUS;
							work.expiry     = expiry_sum;
							if (cur.mode != mec_pkg::MODE_COMPANION) begin
								work.entry_time = event_time;
							end
							chg = (cur.mode != mec_pkg::MODE_COMPANION)
								|| (cur.expr != mec_pkg::EXPR_CURIOUS) || (expiry_sum != '0);
						end
						mec_pkg::OP_MOTION: begin
							if (cur.mode != mec_pkg::MODE_IDLE
								&& cur.mode != mec_pkg::MODE_COMPANION) begin
								ok  = 1'b0;
								why = mec_pkg::REASON_CONTEXT;
							end else begin
								work.expr   = mec_pkg::EXPR_CURIOUS;
								work.expiry = expiry_sum;
								chg = (cur.expr != mec_pkg::EXPR_CURIOUS)
									|| (cur.expiry != expiry_sum);
							end
						end
						mec_pkg::OP_SHAKE: begin
							work.expr   = mec_pkg::EXPR_WARNING;
							work.expiry = expiry_sum;
							chg = (cur.expr != mec_pkg::EXPR_WARNING)
								|| (cur.expiry != expiry_sum);
						end
						mec_pkg::OP_TRAIN_OK: begin
							if (cur.mode != mec_pkg::MODE_TRAINING) begin
								ok  = 1'b0;
								why = mec_pkg::REASON_CONTEXT;
							end else begin
								work.expr   = mec_pkg::EXPR_ENCOURAGING;
								work.expiry = expiry_sum;
								chg = (cur.expr != mec_pkg::EXPR_ENCOURAGING)
									|| (cur.expiry != expiry_sum);
							end
						end
						mec_pkg::OP_SET_MODE: begin
							if (target_mode > 3'(mec_pkg::MODE_ERROR)) begin
								ok  = 1'b0;
								why = mec_pkg::REASON_CONTEXT;
							end else begin
								work.mode   = req;
								work.expr   = mec_pkg::base_expr(req);
								work.expiry = '0;
								if (cur.mode != req) begin
									work.entry_time = event_time;
								end
								chg = (cur.mode != req) || (cur.expr != mec_pkg::base_expr(req));
							end
						end
						mec_pkg::OP_PING: begin
							chg = 1'b0;
						end
						default: begin
							ok  = 1'b0;
							why = mec_pkg::REASON_ROUTE;
						end
					endcase
				end
			end
		endcase
	end

	always_comb begin
		nxt = work;
		if (ok && chg) begin
			nxt.revision = cur.revision + mec_pkg::TimeWidth'(1);
		end
		res.accepted = ok;
		res.changed  = ok && chg;
		res.reason   = why;
		res.mode     = nxt.mode;
		res.expr     = nxt.expr;
		res.alert    = nxt.latch;
		res.revision = nxt.revision;
		res.expiry   = nxt.expiry;
	end

endmodule

### hw/rtl/mode_and_expression_controller_top.sv
// Top level of the mode and expression controller with its handshake, configuration and state.
// The controller takes one event beat per clock cycle while the output is not stalled, and
// passes each result through the input register, where the whole decision against the
// current state is made by a single pass of logic including one 32-bit add for the expiry
// time, and then through the result register. State is written as a beat leaves the input
// register, so back-to-back beats each see the effect of the one before. A stalled result
// holds the result register; the input register keeps taking beats until it is full too.
// The four hold-time registers are written through the configuration port, which is
// always ready and should only be used while no event is in flight.
`include "assert_macros.svh"

module mode_and_expression_controller_top (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             in_valid,
	output logic                             in_stall,
	input  logic [3:0]                       operation,
	input  logic [mec_pkg::TimeWidth-1:0]    event_time,
	input  logic [2:0]                       target_mode,
	output logic                             out_valid,
	input  logic                             out_stall,
	output logic                             accepted,
	output logic                             changed,
	output logic [2:0]                       reason,
	output logic [2:0]                       mode_now,
	output logic [2:0]                       expression_now,
	output logic                             alert_active,
	output logic [mec_pkg::TimeWidth-1:0]    revision_now,
	output logic [mec_pkg::TimeWidth-1:0]    expiry_now,
	input  logic                             cfg_valid,
	output logic                             cfg_ready,
	input  logic [1:0]                       cfg_index,
	input  logic [mec_pkg::HoldWidth-1:0]    cfg_data
);

	mec_pkg::holds_t               holds_q;
	mec_pkg::state_t               state_q;
	mec_pkg::state_t               state_nxt;
	mec_pkg::result_t              res;
	mec_pkg::result_t              res_s2;
	logic                          out_valid_s2;
	logic                          in_valid_s1;
	logic [3:0]                    op_s1;
	logic [mec_pkg::TimeWidth-1:0] time_s1;
	logic [2:0]                    req_s1;
	logic                          s2_free;
	logic                          s1_adv;
	logic                          in_take;

	assign cfg_ready = 1'b1;
	assign s2_free   = !out_valid_s2 || !out_stall;
	assign s1_adv    = in_valid_s1 && s2_free;
	assign in_stall  = in_valid_s1 && !s2_free;
	assign in_take   = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			holds_q <= '{
				touch:  mec_pkg::TouchHoldReset,
				motion: mec_pkg::MotionHoldReset,
				shake:  mec_pkg::ShakeHoldReset,
				reward: mec_pkg::RewardHoldReset
			};
		end else if (cfg_valid && cfg_ready) begin
			unique case (mec_pkg::cfg_reg_t'(cfg_index))
				mec_pkg::REG_TOUCH_HOLD:  holds_q.touch  <= cfg_data;
				mec_pkg::REG_MOTION_HOLD: holds_q.motion <= cfg_data;
				mec_pkg::REG_SHAKE_HOLD:  holds_q.shake  <= cfg_data;
				mec_pkg::REG_REWARD_HOLD: holds_q.reward <= cfg_data;
				default:                  holds_q        <= holds_q;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (in_take) begin
			in_valid_s1 <= 1'b1;
		end else if (s1_adv) begin
			in_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			op_s1   <= operation;
			time_s1 <= event_time;
			req_s1  <= target_mode;
		end
	end

	mec_step u_step (
		.cur            (state_q),
		.holds          (holds_q),
		.operation      (op_s1),
		.event_time     (time_s1),
		.target_mode    (req_s1),
		.nxt            (state_nxt),
		.res            (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{
				mode:       mec_pkg::MODE_IDLE,
				expr:       mec_pkg::EXPR_NEUTRAL,
				expiry:     '0,
				latch:      1'b0,
				entry_time: '0,
				touch_time: '0,
				revision:   '0
			};
		end else if (s1_adv) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_s2 <= 1'b0;
		end else if (s1_adv) begin
			out_valid_s2 <= 1'b1;
		end else if (!out_stall) begin
			out_valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			res_s2 <= res;
		end
	end

	assign out_valid      = out_valid_s2;
	assign accepted       = res_s2.accepted;
	assign changed        = res_s2.changed;
	assign reason         = res_s2.reason;
	assign mode_now       = res_s2.mode;
	assign expression_now = res_s2.expr;
	assign alert_active   = res_s2.alert;
	assign revision_now   = res_s2.revision;
	assign expiry_now     = res_s2.expiry;

	`ASSERT_ALWAYS(a_latch_in_alert, clk, arst_n,
		!state_q.latch || state_q.mode == mec_pkg::MODE_ALERT, "Alert latch set outside alert mode.")
	`ASSERT_NEXT(a_rev_step, clk, arst_n, s1_adv && res.changed,
		state_q.revision == $past(state_q.revision) + mec_pkg::TimeWidth'(1),
		"Revision did not advance by one on a change.")
	`ASSERT_NEXT(a_reject_holds, clk, arst_n, s1_adv && !res.accepted, $stable(state_q),
		"A rejected beat altered the state.")
	`ASSERT_NEXT(a_entry_time, clk, arst_n, s1_adv && state_nxt.mode != state_q.mode,
		state_q.entry_time == $past(time_s1), "Mode entry time missed a mode change.")
	`ASSERT_NEXT(a_touch_time, clk, arst_n,
		s1_adv && res.accepted && (op_s1 == mec_pkg::OP_TAP || op_s1 == mec_pkg::OP_LONG_PRESS),
		state_q.touch_time == $past(time_s1), "Last touch time not taken on a touch.")

endmodule

### tb/tb_top.sv
// Self-checking testbench for the mode and expression controller top level.
`timescale 1ns / 100ps

module tb_top;

	localparam logic [3:0] OP_SPARE_E = 4'd14;
	localparam logic [3:0] OP_SPARE_F = 4'd15;
	localparam logic [2:0] MODE_CODE_RSV_A = 3'd6;
	localparam logic [2:0] MODE_CODE_RSV_B = 3'd7;
	localparam int LONG_HOLD = 120;
	localparam int CYCLE_LIMIT = 400000;
	localparam int REPORT_LIMIT = 10;

	class controller_scoreboard;
		mec_pkg::mode_t mode;
		mec_pkg::expr_t expr;
		logic [mec_pkg::TimeWidth-1:0] expiry;
		logic latch;
		logic [mec_pkg::TimeWidth-1:0] entry_time;
		logic [mec_pkg::TimeWidth-1:0] touch_time;
		logic [mec_pkg::TimeWidth-1:0] revision;
		logic [mec_pkg::HoldWidth-1:0] touch_hold;
		logic [mec_pkg::HoldWidth-1:0] motion_hold;
		logic [mec_pkg::HoldWidth-1:0] shake_hold;
		logic [mec_pkg::HoldWidth-1:0] reward_hold;
		mec_pkg::result_t expected_results[$];
		int failures;

		function new();
			mode = mec_pkg::MODE_IDLE;
			expr = mec_pkg::EXPR_NEUTRAL;
			expiry = '0;
			latch = 1'b0;
			entry_time = '0;
			touch_time = '0;
			revision = '0;
			touch_hold = mec_pkg::TouchHoldReset;
			motion_hold = mec_pkg::MotionHoldReset;
			shake_hold = mec_pkg::ShakeHoldReset;
			reward_hold = mec_pkg::RewardHoldReset;
			failures = 0;
		endfunction

		function void set_hold(mec_pkg::cfg_reg_t idx, logic [mec_pkg::HoldWidth-1:0] value);
			case (idx)
				mec_pkg::REG_TOUCH_HOLD:  touch_hold = value;
				mec_pkg::REG_MOTION_HOLD: motion_hold = value;
				mec_pkg::REG_SHAKE_HOLD:  shake_hold = value;
				default:                  reward_hold = value;
			endcase
		endfunction

		function mec_pkg::expr_t base_of(mec_pkg::mode_t m);
			case (m)
				mec_pkg::MODE_COMPANION, mec_pkg::MODE_TRAINING: return mec_pkg::EXPR_CURIOUS;
				mec_pkg::MODE_MONITORING:                        return mec_pkg::EXPR_SLEEPY;
				mec_pkg::MODE_ALERT:                             return mec_pkg::EXPR_WARNING;
				mec_pkg::MODE_ERROR:                             return mec_pkg::EXPR_ERROR;
				default:                                         return mec_pkg::EXPR_NEUTRAL;
			endcase
		endfunction

		function bit show(mec_pkg::expr_t e, logic [mec_pkg::TimeWidth-1:0] expiry_at);
			bit diff;
			diff = (expr != e) || (expiry != expiry_at);
			expr = e;
			expiry = expiry_at;
			return diff;
		endfunction

		// The expiry is cleared before the base expression is shown, so a dropped
		// expiry alone does not count as a change here.
		function bit enter(mec_pkg::mode_t m, logic [mec_pkg::TimeWidth-1:0] now);
			bit diff;
			bit shown;
			diff = (mode != m);
			mode = m;
			if (diff) begin
				entry_time = now;
			end
			expiry = '0;
			shown = show(base_of(m), '0);
			return shown || diff;
		endfunction

		function void note_event(logic [3:0] op, logic [mec_pkg::TimeWidth-1:0] now,
				logic [2:0] req);
			mec_pkg::result_t r;
			bit ok;
			bit chg;
			bit step;
			mec_pkg::reason_t why;
			ok = 1'b1;
			chg = 1'b0;
			why = mec_pkg::REASON_NONE;
			if (op == mec_pkg::OP_TICK) begin
				if (expiry != 0 && now >= expiry) begin
					chg = show(base_of(mode), '0);
				end
			end else if (op == mec_pkg::OP_ALERT_RAISE) begin
				latch = 1'b1;
				chg = enter(mec_pkg::MODE_ALERT, now);
				step = show(mec_pkg::EXPR_WARNING, '0);
				chg = step || chg;
			end else if (op == mec_pkg::OP_ALERT_CLEAR) begin
				if (!latch) begin
					ok = 1'b0;
					why = mec_pkg::REASON_NO_ALERT;
				end else begin
					latch = 1'b0;
					chg = enter(mec_pkg::MODE_MONITORING, now);
				end
			end else if (latch) begin
				ok = 1'b0;
				why = mec_pkg::REASON_LATCHED;
			end else begin
				case (op)
					mec_pkg::OP_BOOT: begin
						chg = enter(mec_pkg::MODE_IDLE, now);
					end
					mec_pkg::OP_TAP: begin
						touch_time = now;
						if (mode == mec_pkg::MODE_IDLE) begin
							chg = enter(mec_pkg::MODE_COMPANION, now);
						end
						step = show(mec_pkg::EXPR_HAPPY, now + touch_hold);
						chg = step || chg;
					end
					mec_pkg::OP_LONG_PRESS: begin
						touch_time = now;
						chg = enter(mec_pkg::MODE_COMPANION, now);
						step = show(mec_pkg::EXPR_CURIOUS, now + touch_hold);
						chg = step || chg;
					end
					mec_pkg::OP_MOTION: begin
						if (mode != mec_pkg::MODE_IDLE && mode != mec_pkg::MODE_COMPANION) begin
							ok = 1'b0;
							why = mec_pkg::REASON_CONTEXT;
						end else begin
							chg = show(mec_pkg::EXPR_CURIOUS, now + motion_hold);
						end
					end
					mec_pkg::OP_SHAKE: begin
						chg = show(mec_pkg::EXPR_WARNING, now + shake_hold);
					end
					mec_pkg::OP_TRAIN_OK: begin
						if (mode != mec_pkg::MODE_TRAINING) begin
							ok = 1'b0;
							why = mec_pkg::REASON_CONTEXT;
						end else begin
							chg = show(mec_pkg::EXPR_ENCOURAGING, now + reward_hold);
						end
					end
					mec_pkg::OP_SET_MODE: begin
						if (req > mec_pkg::MODE_ERROR) begin
							ok = 1'b0;
							why = mec_pkg::REASON_CONTEXT;
						end else begin
							chg = enter(mec_pkg::mode_t'(req), now);
						end
					end
					mec_pkg::OP_PING: begin
					end
					default: begin
						ok = 1'b0;
						why = mec_pkg::REASON_ROUTE;
					end
				endcase
			end
			if (ok && chg) begin
				revision = revision + 1;
			end
			if (!ok) begin
				chg = 1'b0;
			end
			r.accepted = ok;
			r.changed = chg;
			r.reason = why;
			r.mode = mode;
			r.expr = expr;
			r.alert = latch;
			r.revision = revision;
			r.expiry = expiry;
			expected_results.push_back(r);
		endfunction

		function void check_result(mec_pkg::result_t got);
			mec_pkg::result_t want;
			if (expected_results.size() == 0) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display("Unexpected result beat: mode=%0d expr=%0d rev=%0h", got.mode,
						got.expr, got.revision);
				end
				return;
			end
			want = expected_results.pop_front();
			if (got.accepted !== want.accepted || got.changed !== want.changed ||
					got.reason !== want.reason || got.mode !== want.mode ||
					got.expr !== want.expr || got.alert !== want.alert ||
					got.revision !== want.revision || got.expiry !== want.expiry) begin
				failures++;
				if (failures <= REPORT_LIMIT) begin
					$display({"Mismatch: expected acc=%0d chg=%0d why=%0d mode=%0d expr=%0d",
						" alert=%0d rev=%0h exp=%0h"},
						want.accepted, want.changed, want.reason, want.mode, want.expr,
						want.alert, want.revision, want.expiry);
					$display({"          actual   acc=%0d chg=%0d why=%0d mode=%0d expr=%0d",
						" alert=%0d rev=%0h exp=%0h"},
						got.accepted, got.changed, got.reason, got.mode, got.expr,
						got.alert, got.revision, got.expiry);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [3:0] operation;
	logic [mec_pkg::TimeWidth-1:0] event_time;
	logic [2:0] target_mode;
	logic out_valid;
	logic out_stall;
	logic accepted;
	logic changed;
	logic [2:0] reason;
	logic [2:0] mode_now;
	logic [2:0] expression_now;
	logic alert_active;
	logic [mec_pkg::TimeWidth-1:0] revision_now;
	logic [mec_pkg::TimeWidth-1:0] expiry_now;
	logic cfg_valid;
	logic cfg_ready;
	logic [1:0] cfg_index;
	logic [mec_pkg::HoldWidth-1:0] cfg_data;

	controller_scoreboard tracker;
	logic hold_request = 1'b0;
	int recv_idle_pct = 0;
	int cycle_count = 0;
	logic [mec_pkg::TimeWidth-1:0] now_ms = '0;

	mode_and_expression_controller_top uut (.*);

	always #2 clk = ~clk;

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	task automatic send_event(input logic [3:0] op, input logic [mec_pkg::TimeWidth-1:0] t,
			input logic [2:0] req);
		in_valid <= 1'b1;
		operation <= op;
		event_time <= t;
		target_mode <= req;
		do @(posedge clk); while (in_stall);
		tracker.note_event(op, t, req);
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (tracker.expected_results.size() != 0);
	endtask

	task automatic write_reg(input mec_pkg::cfg_reg_t idx,
			input logic [mec_pkg::HoldWidth-1:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		tracker.set_hold(idx, value);
	endtask

	task automatic write_holds(input logic [mec_pkg::HoldWidth-1:0] t,
			input logic [mec_pkg::HoldWidth-1:0] m,
			input logic [mec_pkg::HoldWidth-1:0] s, input logic [mec_pkg::HoldWidth-1:0] r);
		write_reg(mec_pkg::REG_TOUCH_HOLD, t);
		write_reg(mec_pkg::REG_MOTION_HOLD, m);
		write_reg(mec_pkg::REG_SHAKE_HOLD, s);
		write_reg(mec_pkg::REG_REWARD_HOLD, r);
		cfg_valid <= 1'b0;
	endtask

	function automatic logic [3:0] pick_op();
		int roll;
		roll = $urandom_range(99);
		if (roll < 20) return mec_pkg::OP_TICK;
		if (roll < 30) return mec_pkg::OP_TAP;
		if (roll < 36) return mec_pkg::OP_LONG_PRESS;
		if (roll < 44) return mec_pkg::OP_MOTION;
		if (roll < 50) return mec_pkg::OP_SHAKE;
		if (roll < 60) return mec_pkg::OP_TRAIN_OK;
		if (roll < 74) return mec_pkg::OP_SET_MODE;
		if (roll < 77) return mec_pkg::OP_PING;
		if (roll < 81) return mec_pkg::OP_BOOT;
		if (roll < 86) return mec_pkg::OP_ALERT_RAISE;
		if (roll < 95) return mec_pkg::OP_ALERT_CLEAR;
		case ($urandom_range(4))
			0:       return mec_pkg::OP_ROUTE_A;
			1:       return mec_pkg::OP_ROUTE_B;
			2:       return mec_pkg::OP_ROUTE_C;
			3:       return OP_SPARE_E;
			default: return OP_SPARE_F;
		endcase
	endfunction

	// Time mostly runs forward in small steps; ticks often land on the expiry or just before it.
	function automatic logic [mec_pkg::TimeWidth-1:0] next_time(input logic [3:0] op);
		int roll;
		roll = $urandom_range(99);
		if (op == mec_pkg::OP_TICK && tracker.expiry != 0 && roll < 30) begin
			now_ms = tracker.expiry - $urandom_range(1);
		end else if (roll < 80) begin
			now_ms = now_ms + $urandom_range(1200);
		end else if (roll < 94) begin
			now_ms = $urandom;
		end else begin
			now_ms = 32'hFFFF_FFFF - $urandom_range(70000);
		end
		return now_ms;
	endfunction

	task automatic run_random(input int send_pct, input int recv_pct, input int count);
		int k;
		logic [3:0] op;
		logic [2:0] req;
		logic [mec_pkg::TimeWidth-1:0] t;
		recv_idle_pct <= recv_pct;
		for (k = 0; k < count; k++) begin
			if (k == count / 3) begin
				hold_request <= ~hold_request;
			end
			if (k == 2 * count / 3) begin
				drain_results();
			end else if (k > 0) begin
				while ($urandom_range(99) < send_pct) begin
					in_valid <= 1'b0;
					@(posedge clk);
				end
			end
			op = pick_op();
			if (op == mec_pkg::OP_SET_MODE && $urandom_range(1) == 0) begin
				req = mec_pkg::MODE_TRAINING;
			end else begin
				req = 3'($urandom_range(7));
			end
			t = next_time(op);
			send_event(op, t, req);
		end
		drain_results();
	endtask

	initial begin
		int receive_hold;
		logic hold_seen;
		mec_pkg::result_t got;
		receive_hold = 0;
		hold_seen = 1'b0;
		out_stall = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (out_valid === 1'b1 && !out_stall) begin
				got.accepted = accepted;
				got.changed = changed;
				got.reason = mec_pkg::reason_t'(reason);
				got.mode = mec_pkg::mode_t'(mode_now);
				got.expr = mec_pkg::expr_t'(expression_now);
				got.alert = alert_active;
				got.revision = revision_now;
				got.expiry = expiry_now;
				tracker.check_result(got);
			end
			if (hold_request != hold_seen && receive_hold == 0) begin
				receive_hold = LONG_HOLD;
				hold_seen = hold_request;
			end
			if (receive_hold > 0) begin
				receive_hold--;
				out_stall <= 1'b1;
			end else begin
				out_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	initial begin
		clk = 1'b0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		operation = '0;
		event_time = '0;
		target_mode = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		tracker = new();
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_event(mec_pkg::OP_TICK, 32'd0, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_PING, 32'd10, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_TAP, 32'd1000, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_TICK, 32'd3500, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_MOTION, 32'd4000, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_LONG_PRESS, 32'd5000, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_SHAKE, 32'd6000, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_TRAIN_OK, 32'd6500, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_SET_MODE, 32'd7000, mec_pkg::MODE_TRAINING);
		send_event(mec_pkg::OP_TRAIN_OK, 32'd7100, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_SET_MODE, 32'd7200, MODE_CODE_RSV_B);
		send_event(mec_pkg::OP_SET_MODE, 32'd7300, mec_pkg::MODE_MONITORING);
		send_event(mec_pkg::OP_MOTION, 32'd7400, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_ROUTE_A, 32'd7500, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_ROUTE_B, 32'd7600, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_ROUTE_C, 32'd7700, mec_pkg::MODE_IDLE);
		send_event(OP_SPARE_E, 32'd7800, mec_pkg::MODE_IDLE);
		send_event(OP_SPARE_F, 32'd7900, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_ALERT_CLEAR, 32'd8000, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_ALERT_RAISE, 32'd9000, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_TAP, 32'd9100, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_TICK, 32'd9200, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_ALERT_CLEAR, 32'd9300, mec_pkg::MODE_IDLE);
		send_event(mec_pkg::OP_SET_MODE, 32'hFFFF_FFFF, mec_pkg::MODE_ERROR);
		send_event(mec_pkg::OP_SET_MODE, 32'd9400, mec_pkg::MODE_ALERT);
		send_event(mec_pkg::OP_BOOT, 32'd0, MODE_CODE_RSV_A);
		send_event(mec_pkg::OP_TAP, 32'hFFFF_F63C, mec_pkg::MODE_IDLE);
		drain_results();

		write_holds(16'd0, 16'($urandom_range(1, 3000)), 16'($urandom_range(500, 4000)),
			16'($urandom_range(500, 4000)));
		run_random(35, 68, 250);
		write_holds(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		run_random(68, 35, 250);
		write_holds(16'($urandom_range(65535)), 16'd0, 16'($urandom_range(5000)), 16'hFFFF);
		run_random(0, 0, 250);

		repeat (10) @(posedge clk);
		if (tracker.failures == 0 && tracker.expected_results.size() == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
